/* hdl/sts_pkg.sv */
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types, constants and helpers for the SQL token scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package sts_pkg;

   localparam int POSITION_BITS = 16;
   localparam int POS_W         = 16;
   localparam logic [POS_W-1:0] POS_LIMIT = (POSITION_BITS >= 16) ? 16'hFFFF :
      16'((32'd1 << POSITION_BITS) - 32'd1);

   localparam int PREFIX_W    = 48;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [PREFIX_W-1:0] KW_SELECT = 48'h53454C454354;
   localparam logic [PREFIX_W-1:0] KW_FROM   = 48'h000046524F4D;
   localparam logic [PREFIX_W-1:0] KW_WHERE  = 48'h005748455245;
   localparam logic [PREFIX_W-1:0] KW_INSERT = 48'h494E53455254;
   localparam logic [PREFIX_W-1:0] KW_INTO   = 48'h0000494E544F;
   localparam logic [PREFIX_W-1:0] KW_VALUES = 48'h56414C554553;

   typedef enum logic [2:0] {
      KIND_KEYWORD = 3'd0,
      KIND_IDENT   = 3'd1,
      KIND_NUMBER  = 3'd2,
      KIND_STRING  = 3'd3,
      KIND_OPER    = 3'd4,
      KIND_PUNCT   = 3'd5,
      KIND_END     = 3'd6
   } token_kind_type;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_WORD = 2'd1,
      MODE_NUM  = 2'd2,
      MODE_STR  = 2'd3
   } scan_mode_type;

   typedef struct packed {
      token_kind_type   kind;
      logic [POS_W-1:0] start;
      logic [POS_W-1:0] length;
      logic [7:0]       sym;
      logic             ovf;
   } token_type;

   typedef struct packed {
      logic      two;
      token_type slot0;
      token_type slot1;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } queue_head_type;

   function automatic logic is_keyword(input logic [PREFIX_W-1:0] prefix,
                                       input logic [POS_W-1:0] len);
      logic hit;
      begin
         hit = ((len == POS_W'(6)) &&
                (prefix == KW_SELECT || prefix == KW_INSERT || prefix == KW_VALUES)) ||
               ((len == POS_W'(4)) && (prefix == KW_FROM || prefix == KW_INTO)) ||
               ((len == POS_W'(5)) && (prefix == KW_WHERE));
         return hit;
      end
   endfunction

endpackage

`default_nettype wire

/* hdl/sql_token_scanner.sv */
// ----------------------------------------------------------------------------
// sql_token_scanner
// Byte-serial SQL lexer: one text byte per transfer in, one token per
// transfer out (kind, start offset, length, symbol byte).
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | char_byte, end_marker
//   rsp     | out       | rsp_valid/rsp_ready  | token_kind, start_offset,
//           |           |                      | token_length, symbol_char,
//           |           |                      | position_overflow, run_last
//
// One byte is accepted per cycle while the four-entry token queue has room.
// A byte that closes a token and is itself a symbol yields two tokens, which
// leave in turn; the output port moves one token per cycle while rsp_ready is high.
// Reset is synchronous and clears scan state, queue and output stage.
// A stalled rsp side fills the queue and then drops req_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module sql_token_scanner (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_char_byte,
   input  wire logic        req_end_marker,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_token_kind,
   output logic [15:0]      rsp_start_offset,
   output logic [15:0]      rsp_token_length,
   output logic [7:0]       rsp_symbol_char,
   output logic             rsp_position_overflow,
   output logic             rsp_run_last
);
   import sts_pkg::*;

   logic           accept, push, full, pop;
   entry_type      push_entry;
   queue_head_type head;
   token_type      tok;

   assign req_ready = !full;
   assign accept    = req_valid && req_ready;

   sts_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .char_byte  (req_char_byte),
      .end_marker (req_end_marker),
      .push       (push),
      .push_entry (push_entry)
   );

   sts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .head       (head)
   );

   sts_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_token (tok),
      .rsp_last  (rsp_run_last)
   );

   assign rsp_token_kind        = tok.kind;
   assign rsp_start_offset      = tok.start;
   assign rsp_token_length      = tok.length;
   assign rsp_symbol_char       = tok.sym;
   assign rsp_position_overflow = tok.ovf;

endmodule

`default_nettype wire

/* hdl/sts_front.sv */
// ----------------------------------------------------------------------------
// sts_front
// Byte classifier and scan state; builds at most one queue entry, of up to two
// tokens, per accepted byte.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_front (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          accept,
   input  wire logic [7:0]    char_byte,
   input  wire logic          end_marker,
   output logic               push,
   output sts_pkg::entry_type push_entry
);
   import sts_pkg::*;

   scan_mode_type       mode_ff, mode_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [POS_W-1:0]    start_ff, start_in;
   logic [PREFIX_W-1:0] prefix_ff, prefix_in;
   logic                ovf_ff, ovf_in;

   logic             is_letter, is_digit, is_word, is_quote, is_oper, is_punct;
   logic [7:0]       upper;
   logic             at_lim, ovf_now;
   logic [POS_W-1:0] next_pos, span_len;
   logic             flush_valid, sym_valid;
   token_type        flush_tok, sym_tok;
   scan_mode_type    mode_after;

   always_comb begin
      is_letter = (char_byte >= 8'h41 && char_byte <= 8'h5A) ||
                  (char_byte >= 8'h61 && char_byte <= 8'h7A);
      is_digit  = char_byte >= 8'h30 && char_byte <= 8'h39;
      is_word   = is_letter || is_digit || char_byte == 8'h5F;
      is_quote  = char_byte == 8'h27;
      is_oper   = char_byte == 8'h3D || char_byte == 8'h3E || char_byte == 8'h3C;
      is_punct  = char_byte == 8'h28 || char_byte == 8'h29 ||
                  char_byte == 8'h2C || char_byte == 8'h3B;
      upper     = (char_byte >= 8'h61 && char_byte <= 8'h7A) ? char_byte - 8'd32 : char_byte;

      at_lim    = pos_ff >= POS_LIMIT;
      next_pos  = at_lim ? pos_ff : pos_ff + POS_W'(1);
      span_len  = (pos_ff >= start_ff) ? pos_ff - start_ff : '0;
      ovf_now   = end_marker ? ovf_ff : (ovf_ff | at_lim);

      flush_tok.start  = start_ff;
      flush_tok.length = span_len;
      flush_tok.sym    = '0;
      flush_tok.ovf    = ovf_now;
      unique case (mode_ff)
         MODE_WORD: flush_tok.kind = is_keyword(prefix_ff, span_len) ? KIND_KEYWORD : KIND_IDENT;
         MODE_NUM:  flush_tok.kind = KIND_NUMBER;
         default:   flush_tok.kind = KIND_STRING;
      endcase

      sym_tok.start  = pos_ff;
      sym_tok.length = POS_W'(1);
      sym_tok.sym    = char_byte;
      sym_tok.ovf    = ovf_now;
      sym_tok.kind   = is_oper ? KIND_OPER : KIND_PUNCT;

      mode_in    = mode_ff;
      pos_in     = next_pos;
      start_in   = start_ff;
      prefix_in  = prefix_ff;
      ovf_in     = ovf_now;
      sym_valid  = 1'b0;
      flush_valid = 1'b0;
      mode_after = mode_ff;

      if (end_marker) begin
         flush_valid = mode_ff != MODE_IDLE;
         sym_valid   = 1'b1;
         sym_tok.kind   = KIND_END;
         sym_tok.length = '0;
         sym_tok.sym    = '0;
         mode_in   = MODE_IDLE;
         pos_in    = '0;
         start_in  = '0;
         prefix_in = '0;
         ovf_in    = 1'b0;
      end else begin
         unique case (mode_ff)
            MODE_WORD: begin
               if (is_word) begin
                  prefix_in = {prefix_ff[PREFIX_W-9:0], upper};
               end else begin
                  flush_valid = 1'b1;
               end
            end
            MODE_NUM:  flush_valid = !is_digit;
            MODE_STR:  flush_valid = is_quote;
            default:   flush_valid = 1'b0;
         endcase
         if (flush_valid) begin
            mode_after = MODE_IDLE;
         end
         mode_in = mode_after;
         if (mode_after == MODE_IDLE && mode_ff != MODE_STR) begin
            if (is_letter || char_byte == 8'h5F) begin
               mode_in   = MODE_WORD;
               start_in  = pos_ff;
               prefix_in = {{(PREFIX_W-8){1'b0}}, upper};
            end else if (is_digit) begin
               mode_in  = MODE_NUM;
               start_in = pos_ff;
            end else if (is_quote) begin
               mode_in  = MODE_STR;
               start_in = next_pos;
            end else if (is_oper || is_punct) begin
               sym_valid = 1'b1;
            end
         end
      end

      push = accept && (flush_valid || sym_valid);
      if (flush_valid) begin
         push_entry.slot0 = flush_tok;
         push_entry.slot1 = sym_tok;
         push_entry.two   = sym_valid;
      end else begin
         push_entry.slot0 = sym_tok;
         push_entry.slot1 = sym_tok;
         push_entry.two   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         pos_ff    <= '0;
         start_ff  <= '0;
         prefix_ff <= '0;
         ovf_ff    <= 1'b0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         pos_ff    <= pos_in;
         start_ff  <= start_in;
         prefix_ff <= prefix_in;
         ovf_ff    <= ovf_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/sts_queue.sv */
// ----------------------------------------------------------------------------
// sts_queue
// Short FIFO of token entries between the scanner front and the output side.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire sts_pkg::entry_type push_entry,
   output logic                    full,
   input  wire logic               pop,
   output sts_pkg::queue_head_type head
);
   import sts_pkg::*;

   entry_type           mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;
   logic                do_pop;

   always_comb begin
      full       = count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH);
      head.valid = count_ff != '0;
      head.entry = mem_ff[rd_ptr_ff];
      do_pop     = pop && head.valid;
      wr_ptr_in  = push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in  = do_pop ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in   = count_ff + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/sts_back.sv */
// ----------------------------------------------------------------------------
// sts_back
// Output side: unpacks queue entries into single token transfers through a
// registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire sts_pkg::queue_head_type head,
   output logic                         pop,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output sts_pkg::token_type           rsp_token,
   output logic                         rsp_last
);
   import sts_pkg::*;

   logic      valid_ff, valid_in;
   logic      sel_ff, sel_in;
   token_type tok_ff;
   logic      last_ff;
   logic      load, last_slot;
   token_type cur;

   always_comb begin
      load      = head.valid && (!valid_ff || rsp_ready);
      cur       = sel_ff ? head.entry.slot1 : head.entry.slot0;
      last_slot = !head.entry.two || sel_ff;
      pop       = load && last_slot;
      sel_in    = load ? !last_slot : sel_ff;
      valid_in  = load ? 1'b1 : (valid_ff && !rsp_ready);
      rsp_valid = valid_ff;
      rsp_token = tok_ff;
      rsp_last  = last_ff;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         tok_ff  <= cur;
         last_ff <= last_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/sts_checker.sv */
// ----------------------------------------------------------------------------
// sts_checker
// Port-level checks on the token scanner's result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_token_kind,
   input wire logic [15:0] rsp_start_offset,
   input wire logic [15:0] rsp_token_length,
   input wire logic [7:0]  rsp_symbol_char,
   input wire logic        rsp_run_last
);
   import sts_pkg::*;

   hold_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_start_offset) &&
      $stable(rsp_token_kind) && $stable(rsp_token_length))
      else $error("result changed while stalled");

   end_token: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind == KIND_END |->
      rsp_token_length == 16'd0 && rsp_run_last && rsp_symbol_char == 8'd0)
      else $error("malformed end token");

   symbol_token: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_token_kind == KIND_OPER || rsp_token_kind == KIND_PUNCT) |->
      rsp_token_length == 16'd1 && rsp_run_last && rsp_symbol_char != 8'd0)
      else $error("malformed symbol token");

   text_token: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_token_kind == KIND_KEYWORD || rsp_token_kind == KIND_IDENT ||
                    rsp_token_kind == KIND_NUMBER || rsp_token_kind == KIND_STRING) |->
      rsp_symbol_char == 8'd0)
      else $error("symbol byte on text token");

endmodule

bind sql_token_scanner sts_checker u_sts_checker (.*);

`default_nettype wire
